// ----- src/scta_pkg.sv -----
// Shared types, codes and scan code tables for the scan code to ASCII block.
// No dependencies; every other file in src but scta_ram imports this package.
package scta_pkg;

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_PUSH  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] scan_byte;
    } key_item_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic [6:0] modifier_bits;
        logic       has_data;
        logic       dropped;
        logic       led_update;
        logic [2:0] led_bits;
    } res_item_t;

    // One classified beat handed from the front to the back.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [6:0] ch;
        logic [6:0] mods;
        logic       led_update;
        logic [2:0] led_bits;
    } cmd_t;

    localparam logic [7:0] BYTE_PREFIX  = 8'hE0;
    localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT   = 7'h36;
    localparam logic [6:0] KEY_CTRL     = 7'h1D;
    localparam logic [6:0] KEY_ALT      = 7'h38;
    localparam logic [6:0] KEY_CAPS     = 7'h3A;

    localparam int MOD_LSHIFT = 0;
    localparam int MOD_RSHIFT = 1;
    localparam int MOD_LCTRL  = 2;
    localparam int MOD_RCTRL  = 3;
    localparam int MOD_LALT   = 4;
    localparam int MOD_RALT   = 5;
    localparam int MOD_CAPS   = 6;

    localparam logic [2:0] LED_CAPS_ON = 3'd4;
    localparam logic [6:0] CHAR_LOW_A  = 7'h61;
    localparam logic [6:0] CHAR_LOW_Z  = 7'h7A;

    // US QWERTY, unshifted
    function automatic logic [6:0] plain_char(input logic [6:0] key);
        logic [6:0] ch;
        case (key)
            7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
            7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
            7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
            7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
            7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;
            7'h14: ch = 7'h74;  7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;
            7'h18: ch = 7'h6F;  7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
            7'h1C: ch = 7'h0A;  7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;
            7'h20: ch = 7'h64;  7'h21: ch = 7'h66;  7'h22: ch = 7'h67;  7'h23: ch = 7'h68;
            7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;  7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;
            7'h28: ch = 7'h27;  7'h29: ch = 7'h60;  7'h2B: ch = 7'h5C;  7'h2C: ch = 7'h7A;
            7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;  7'h2F: ch = 7'h76;
            7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;
            7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;  7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
            7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34;  7'h4C: ch = 7'h35;  7'h4D: ch = 7'h36;  7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31;  7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

    // US QWERTY, shifted
    function automatic logic [6:0] shifted_char(input logic [6:0] key);
        logic [6:0] ch;
        case (key)
            7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;  7'h05: ch = 7'h24;
            7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;
            7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
            7'h0E: ch = 7'h08;  7'h0F: ch = 7'h09;
            7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;
            7'h14: ch = 7'h54;  7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;
            7'h18: ch = 7'h4F;  7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
            7'h1C: ch = 7'h0A;  7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;
            7'h20: ch = 7'h44;  7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
            7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;  7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;
            7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;  7'h2B: ch = 7'h7C;  7'h2C: ch = 7'h5A;
            7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;  7'h2F: ch = 7'h56;
            7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;
            7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;  7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
            7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4A: ch = 7'h2D;
            7'h4B: ch = 7'h34;  7'h4C: ch = 7'h35;  7'h4D: ch = 7'h36;  7'h4E: ch = 7'h2B;
            7'h4F: ch = 7'h31;  7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;
            7'h53: ch = 7'h2E;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- src/scancode_to_ascii_with_fifo.sv -----
// Set 1 scan code to ASCII decoder with a character ring buffer. Each key beat
// is a scan byte, a pop or a clear; every accepted beat yields exactly one
// result beat. Throughput is one beat per clock unless res_stall holds it;
// an accepted beat passes the front-to-back command queue, then the result
// register that also holds the registered RAM read. The buffer
// holds FIFO_DEPTH-1 characters in one RAM with one write and one read port;
// a push into a full buffer is discarded and flagged. The RAM is not cleared
// after reset, so the block takes beats from the first cycle out of reset.
// Depends on scta_pkg, scta_front, scta_queue, scta_back, scta_ram.
module scancode_to_ascii_with_fifo #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_stall,
    input  scta_pkg::key_item_t key_item,
    output logic                res_valid,
    input  logic                res_stall,
    output scta_pkg::res_item_t res_item
);
    import scta_pkg::*;

    cmd_t front_cmd;
    cmd_t head;
    logic q_full;
    logic head_valid;
    logic accept;
    logic take;

    assign key_stall = q_full;
    assign accept    = key_valid && !q_full;

    scta_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (accept),
        .item  (key_item),
        .cmd   (front_cmd)
    );

    scta_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (front_cmd),
        .full       (q_full),
        .pop        (take),
        .head_valid (head_valid),
        .head       (head)
    );

    scta_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .take       (take),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

    // a drop only happens on a full buffer, which cannot read as empty
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.dropped |-> res_item.has_data)
        else $error("dropped beat reports an empty buffer");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.led_update |-> res_item.led_bits == 3'd0)
        else $error("led bits set without an led update");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.led_update
            |-> (res_item.led_bits == LED_CAPS_ON) == res_item.modifier_bits[MOD_CAPS])
        else $error("led bits disagree with caps lock state");

    // a popped character comes with no drop and no led request
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.char_out != 7'h00
            |-> !res_item.dropped && !res_item.led_update)
        else $error("pop beat carries decode flags");

endmodule

// ----- src/scta_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module scta_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/scta_front.sv -----
// Front end: decodes scan bytes, tracks modifiers and the extended prefix,
// and classifies each accepted beat into a command. Depends on scta_pkg.
module scta_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  scta_pkg::key_item_t item,
    output scta_pkg::cmd_t    cmd
);
    import scta_pkg::*;

    logic [6:0] mods_reg;
    logic [6:0] mods_next;
    logic       prefix_reg;
    logic       prefix_next;

    logic       release_key;
    logic [6:0] key;
    logic       handled;
    logic       shift;
    logic [6:0] plain;
    logic [6:0] ch;
    logic       led;

    assign release_key = item.scan_byte[7];
    assign key         = item.scan_byte[6:0];
    assign plain       = plain_char(key);

    always_comb
    begin
        shift = mods_reg[MOD_LSHIFT] | mods_reg[MOD_RSHIFT];
        if (plain >= CHAR_LOW_A && plain <= CHAR_LOW_Z && mods_reg[MOD_CAPS])
        begin
            shift = !shift;
        end
        ch = shift ? shifted_char(key) : plain;
    end

    always_comb
    begin
        mods_next   = mods_reg;
        prefix_next = prefix_reg;
        handled     = 1'b1;
        led         = 1'b0;
        cmd         = '0;
        cmd.kind    = CMD_NONE;
        case (item.operation)
            OP_SCAN:
            begin
                if (item.scan_byte == BYTE_PREFIX)
                begin
                    prefix_next = 1'b1;
                end
                else
                begin
                    prefix_next = 1'b0;
                    if (!prefix_reg)
                    begin
                        case (key)
                            KEY_LSHIFT: mods_next[MOD_LSHIFT] = !release_key;
                            KEY_RSHIFT: mods_next[MOD_RSHIFT] = !release_key;
                            KEY_CTRL:   mods_next[MOD_LCTRL]  = !release_key;
                            KEY_ALT:    mods_next[MOD_LALT]   = !release_key;
                            KEY_CAPS:
                            begin
                                if (!release_key)
                                begin
                                    mods_next[MOD_CAPS] = !mods_reg[MOD_CAPS];
                                    led                 = 1'b1;
                                end
                            end
                            default: handled = 1'b0;
                        endcase
                    end
                    else
                    begin
                        case (key)
                            KEY_CTRL: mods_next[MOD_RCTRL] = !release_key;
                            KEY_ALT:  mods_next[MOD_RALT]  = !release_key;
                            default:  handled = 1'b0;
                        endcase
                    end
                    // unmapped keys look up as zero and produce nothing
                    if (!handled && !release_key && ch != 7'h00)
                    begin
                        cmd.kind = CMD_PUSH;
                        cmd.ch   = ch;
                    end
                end
            end
            OP_POP:   cmd.kind = CMD_POP;
            OP_CLEAR: cmd.kind = CMD_CLEAR;
            default:  cmd.kind = CMD_NONE;
        endcase
        cmd.mods       = mods_next;
        cmd.led_update = led;
        cmd.led_bits   = (led && mods_next[MOD_CAPS]) ? LED_CAPS_ON : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg   <= '0;
            prefix_reg <= 1'b0;
        end
        else if (take)
        begin
            mods_reg   <= mods_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

// ----- src/scta_queue.sv -----
// Two-entry command queue between front and back ends.
// Depends on scta_pkg.
module scta_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  scta_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output scta_pkg::cmd_t head
);
    import scta_pkg::*;

    localparam int SLOTS = 2;

    cmd_t       slot_reg [SLOTS];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'(SLOTS));
    assign head_valid = (count_reg != 2'd0);
    assign head       = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = pop ? !rptr_reg : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/scta_back.sv -----
// Back end: character ring buffer (indices plus RAM) and the result register.
// Depends on scta_pkg and scta_ram.
module scta_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  scta_pkg::cmd_t      head,
    output logic                take,
    output logic                res_valid,
    input  logic                res_stall,
    output scta_pkg::res_item_t res_item
);
    import scta_pkg::*;

    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);

    logic [IDX_W-1:0] rd_reg;
    logic [IDX_W-1:0] rd_next;
    logic [IDX_W-1:0] wr_reg;
    logic [IDX_W-1:0] wr_next;
    logic [IDX_W-1:0] rd_inc;
    logic [IDX_W-1:0] wr_inc;

    logic       valid_reg;
    logic       pop_hit_reg;
    logic       pop_hit;
    res_item_t  res_reg;
    res_item_t  res_next;
    logic       advance;
    logic       we;
    logic       re;
    logic [6:0] rdata;

    // the result register frees up when empty or when its beat leaves
    assign advance = !valid_reg || !res_stall;
    assign take    = head_valid && advance;

    assign rd_inc = (rd_reg == LAST_IDX) ? '0 : rd_reg + 1'b1;
    assign wr_inc = (wr_reg == LAST_IDX) ? '0 : wr_reg + 1'b1;

    always_comb
    begin
        rd_next  = rd_reg;
        wr_next  = wr_reg;
        we       = 1'b0;
        re       = 1'b0;
        pop_hit  = 1'b0;
        res_next = '0;
        case (head.kind)
            CMD_PUSH:
            begin
                if (wr_inc == rd_reg)
                begin
                    res_next.dropped = 1'b1;
                end
                else
                begin
                    we      = take;
                    wr_next = wr_inc;
                end
            end
            CMD_POP:
            begin
                if (rd_reg != wr_reg)
                begin
                    re      = take;
                    pop_hit = 1'b1;
                    rd_next = rd_inc;
                end
            end
            CMD_CLEAR:
            begin
                rd_next = '0;
                wr_next = '0;
            end
            default:
            begin
            end
        endcase
        res_next.modifier_bits = head.mods;
        res_next.has_data      = (rd_next != wr_next);
        res_next.led_update    = head.led_update;
        res_next.led_bits      = head.led_bits;
    end

    scta_ram #(
        .WIDTH (7),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (wr_reg),
        .wdata (head.ch),
        .re    (re),
        .raddr (rd_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg      <= '0;
            wr_reg      <= '0;
            valid_reg   <= 1'b0;
            pop_hit_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= head_valid;
            if (head_valid)
            begin
                rd_reg      <= rd_next;
                wr_reg      <= wr_next;
                pop_hit_reg <= pop_hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    // merge the registered RAM read into the held result beat
    always_comb
    begin
        res_item = res_reg;
        if (!pop_hit_reg)
        begin
            res_item.char_out = 7'h00;
        end
        else
        begin
            res_item.char_out = rdata;
        end
    end

    assign res_valid = valid_reg;

endmodule

// ----- dv/scancode_to_ascii_with_fifo_test.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the set 1 scan code decoder and its character FIFO.
// Needs scta_pkg and scancode_to_ascii_with_fifo from src; predicts every result beat.
module scancode_to_ascii_with_fifo_test;
    import scta_pkg::*;

    localparam int         FIFO_DEPTH      = 256;
    localparam int         ITEM_TARGET     = 1300;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         WATCHDOG_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES    = 8;
    localparam int         MAX_PRINTED     = 30;
    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam logic [7:0] RELEASE_BIT     = 8'h80;

    // Tracks modifier, prefix and FIFO state; one expected result per key beat.
    class scan_decode_board;
        int       depth;
        bit [6:0] store[];
        int       rd_ptr;
        int       wr_ptr;
        bit [6:0] mods;
        bit       e0_armed;
        bit [6:0] plain_tab[128];
        bit [6:0] shift_tab[128];
        res_item_t decoded_q[$];
        int       errors;
        int       checked;
        int       chars_popped;
        int       drops;
        int       led_requests;
        int       clears;

        function new(int fifo_depth);
            depth = fifo_depth;
            store = new[fifo_depth];
            foreach (store[i]) store[i] = '0;
            foreach (plain_tab[i])
            begin
                plain_tab[i] = '0;
                shift_tab[i] = '0;
            end
            put_row('h02, "1234567890-=", "!@#$%^&*()_+");
            // backspace and tab
            put_row('h0E, "\010\t", "\010\t");
            put_row('h10, "qwertyuiop[]\n", "QWERTYUIOP{}\n");
            // last entry is the grave accent
            put_row('h1E, "asdfghjkl;'\140", "ASDFGHJKL:\"~");
            put_row('h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
            put_row('h37, "*", "*");
            put_row('h39, " ", " ");
            put_row('h47, "789-456+1230.", "789-456+1230.");
            rd_ptr = 0;
            wr_ptr = 0;
            mods = '0;
            e0_armed = 1'b0;
            errors = 0;
            checked = 0;
            chars_popped = 0;
            drops = 0;
            led_requests = 0;
            clears = 0;
        endfunction

        function void put_row(int first, string lo, string hi);
            for (int i = 0; i < lo.len(); i++)
            begin
                plain_tab[first + i] = 7'(lo[i]);
                shift_tab[first + i] = 7'(hi[i]);
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void note_key_beat(key_item_t it);
            res_item_t r;
            bit [6:0]  key;
            bit [6:0]  ch;
            bit        rel;
            bit        known;
            bit        shift;
            bit        ext;
            r = '0;
            case (it.operation)
                OP_SCAN:
                begin
                    if (it.scan_byte == BYTE_PREFIX)
                    begin
                        e0_armed = 1'b1;
                    end
                    else
                    begin
                        rel = it.scan_byte[7];
                        key = it.scan_byte[6:0];
                        ext = e0_armed;
                        e0_armed = 1'b0;
                        known = 1'b1;
                        if (!ext)
                        begin
                            case (key)
                                KEY_LSHIFT: mods[MOD_LSHIFT] = !rel;
                                KEY_RSHIFT: mods[MOD_RSHIFT] = !rel;
                                KEY_CTRL:   mods[MOD_LCTRL] = !rel;
                                KEY_ALT:    mods[MOD_LALT] = !rel;
                                KEY_CAPS:
                                begin
                                    if (!rel)
                                    begin
                                        mods[MOD_CAPS] = !mods[MOD_CAPS];
                                        r.led_update = 1'b1;
                                        r.led_bits = mods[MOD_CAPS] ? LED_CAPS_ON : 3'd0;
                                    end
                                end
                                default: known = 1'b0;
                            endcase
                        end
                        else
                        begin
                            case (key)
                                KEY_CTRL: mods[MOD_RCTRL] = !rel;
                                KEY_ALT:  mods[MOD_RALT] = !rel;
                                default:  known = 1'b0;
                            endcase
                        end
                        if (!known && !rel)
                        begin
                            shift = mods[MOD_LSHIFT] | mods[MOD_RSHIFT];
                            ch = plain_tab[key];
                            // caps lock flips shift on letters only
                            if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z && mods[MOD_CAPS])
                                shift = !shift;
                            if (shift)
                                ch = shift_tab[key];
                            if (ch != '0)
                            begin
                                if ((wr_ptr + 1) % depth == rd_ptr)
                                begin
                                    r.dropped = 1'b1;
                                end
                                else
                                begin
                                    store[wr_ptr] = ch;
                                    wr_ptr = (wr_ptr + 1) % depth;
                                end
                            end
                        end
                    end
                end
                OP_POP:
                begin
                    if (rd_ptr != wr_ptr)
                    begin
                        r.char_out = store[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % depth;
                    end
                end
                OP_CLEAR:
                begin
                    rd_ptr = 0;
                    wr_ptr = 0;
                end
                default: ;
            endcase
            r.modifier_bits = mods;
            r.has_data = (rd_ptr != wr_ptr);
            if (r.char_out != '0) chars_popped++;
            if (r.dropped) drops++;
            if (r.led_update) led_requests++;
            if (it.operation == OP_CLEAR) clears++;
            decoded_q.push_back(r);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        endtask

        task check_result_beat(res_item_t got);
            res_item_t want;
            if (decoded_q.size() == 0)
            begin
                report_mismatch("unexpected result beat", got, 0);
                return;
            end
            want = decoded_q.pop_front();
            checked++;
            if (got.char_out !== want.char_out)
                report_mismatch("char_out", got.char_out, want.char_out);
            if (got.modifier_bits !== want.modifier_bits)
                report_mismatch("modifier_bits", got.modifier_bits, want.modifier_bits);
            if (got.has_data !== want.has_data)
                report_mismatch("has_data", got.has_data, want.has_data);
            if (got.dropped !== want.dropped)
                report_mismatch("dropped", got.dropped, want.dropped);
            if (got.led_update !== want.led_update)
                report_mismatch("led_update", got.led_update, want.led_update);
            if (got.led_bits !== want.led_bits)
                report_mismatch("led_bits", got.led_bits, want.led_bits);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      key_valid;
    logic      key_stall;
    key_item_t key_item;
    logic      res_valid;
    logic      res_stall;
    res_item_t res_item;

    scan_decode_board board;
    int               items_sent;
    int               burst_left;
    bit               hold_req;

    scancode_to_ascii_with_fifo #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_valid(key_valid),
        .key_stall(key_stall),
        .key_item (key_item),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_item (res_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall pattern rotates through four modes; a long hold-off on request.
    initial
    begin : res_stall_gen
        int cyc;
        cyc = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            case ((cyc / 256) % 4)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 99) < 25);
                2: res_stall <= ((cyc % 7) < 3);
                default: res_stall <= ($urandom_range(0, 99) < 75);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            board.check_result_beat(res_item);
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((key_valid && !key_stall) || (res_valid && !res_stall))
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, board.pending());
        $display("CHECKS FAILED");
        $finish;
    end

    // Drive one key beat; bursts of random length separated by idle gaps.
    task automatic send(input logic [1:0] op, input logic [7:0] scan);
        key_item_t it;
        if (burst_left == 0)
        begin
            key_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 15)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
        end
        it.operation = op;
        it.scan_byte = scan;
        key_item  <= it;
        key_valid <= 1'b1;
        do @(posedge clk); while (key_stall);
        board.note_key_beat(it);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        key_valid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic press(input logic [6:0] key);
        send(OP_SCAN, {1'b0, key});
    endtask

    task automatic release_key(input logic [6:0] key);
        send(OP_SCAN, RELEASE_BIT | {1'b0, key});
    endtask

    task automatic tap(input logic [6:0] key, input bit ext);
        if (ext) send(OP_SCAN, BYTE_PREFIX);
        press(key);
        if (ext) send(OP_SCAN, BYTE_PREFIX);
        release_key(key);
    endtask

    function automatic logic [6:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 7'($urandom_range('h02, 'h39));
        if (r < 85) return 7'($urandom_range('h47, 'h53));
        return 7'($urandom_range(0, 'h7F));
    endfunction

    // One stretch of mixed traffic: mostly well-formed key sequences.
    task automatic random_phase(input int n_items, input int pop_pct);
        int         stop_at;
        int         r;
        logic [6:0] mod_key;
        bit         ext;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < pop_pct)
                send(OP_POP, 8'($urandom_range(0, 255)));
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    send(OP_CLEAR, 8'($urandom_range(0, 255)));
                else if (r < 5)
                    send(OP_UNUSED, 8'($urandom_range(0, 255)));
                else if (r < 12)
                    send(OP_SCAN, 8'($urandom_range(0, 255)));
                else if (r < 50)
                    tap(pick_key(), $urandom_range(0, 9) == 0);
                else if (r < 65)
                begin
                    mod_key = $urandom_range(0, 1) ? KEY_LSHIFT : KEY_RSHIFT;
                    press(mod_key);
                    repeat ($urandom_range(1, 5)) tap(pick_key(), 1'b0);
                    release_key(mod_key);
                end
                else if (r < 72)
                    tap(KEY_CAPS, 1'b0);
                else if (r < 84)
                begin
                    mod_key = $urandom_range(0, 1) ? KEY_CTRL : KEY_ALT;
                    ext = 1'($urandom_range(0, 1));
                    if (ext) send(OP_SCAN, BYTE_PREFIX);
                    press(mod_key);
                    tap(pick_key(), 1'b0);
                    if (ext) send(OP_SCAN, BYTE_PREFIX);
                    release_key(mod_key);
                end
                else if (r < 92)
                begin
                    // typematic repeat: several makes, one break
                    mod_key = pick_key();
                    repeat ($urandom_range(2, 6)) press(mod_key);
                    release_key(mod_key);
                end
                else
                    repeat ($urandom_range(1, 3)) send(OP_SCAN, BYTE_PREFIX);
            end
        end
    endtask

    initial
    begin
        board = new(FIFO_DEPTH);
        items_sent = 0;
        burst_left = 0;
        hold_req = 1'b0;
        rst_n     <= 1'b0;
        key_valid <= 1'b0;
        key_item  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, unused code, caps and shift interplay, prefixes
        send(OP_POP, 8'h00);
        send(OP_UNUSED, 8'hFF);
        press(7'h1E);
        release_key(7'h1E);
        press(KEY_CAPS);
        press(7'h1E);
        press(7'h02);
        press(KEY_RSHIFT);
        press(7'h1E);
        press(7'h02);
        release_key(KEY_RSHIFT);
        release_key(KEY_CAPS);
        press(KEY_CAPS);
        send(OP_SCAN, BYTE_PREFIX);
        send(OP_SCAN, BYTE_PREFIX);
        press(KEY_CTRL);
        send(OP_SCAN, BYTE_PREFIX);
        press(KEY_ALT);
        send(OP_SCAN, BYTE_PREFIX);
        press(7'h10);
        press(KEY_LSHIFT);
        press(7'h00);
        press(7'h7F);
        send(OP_SCAN, 8'hFF);
        send(OP_CLEAR, 8'h00);

        // hold the sender until every result is back
        wait_drained();
        random_phase(250, 40);

        // receiver holds off while a run of keys overfills the FIFO
        hold_req = 1'b1;
        repeat (300) press(7'($urandom_range('h10, 'h32)));
        repeat (270) send(OP_POP, 8'($urandom_range(0, 255)));

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0: random_phase($urandom_range(60, 200), 0);
                1: random_phase($urandom_range(60, 200), 10);
                2: random_phase($urandom_range(60, 200), 35);
                default: random_phase($urandom_range(60, 200), 60);
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d key beats, checked %0d results: %0d characters popped,",
                 items_sent, board.checked, board.chars_popped);
        $display("%0d drops on a full FIFO, %0d LED requests, %0d clears, %0d mismatches.",
                 board.drops, board.led_requests, board.clears, board.errors);
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
